/* hdl/ksd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ksd_pkg
// types, request codes and character tables for the scancode decoder
// ----------------------------------------------------------------------------
package ksd_pkg;

    localparam logic [1:0] REQ_SCAN  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [6:0] SHIFT_LEFT_CODE  = 7'h2A;
    localparam logic [6:0] SHIFT_RIGHT_CODE = 7'h36;
    localparam logic [6:0] NO_CHAR          = 7'h3F;
    localparam int         KEY_COUNT        = 128;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] code_byte;
    } ksd_req_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic [6:0] event_scancode;
        logic       event_pressed;
        logic       event_empty;
        logic       key_down;
        logic       event_dropped;
    } ksd_rsp_t;

    // unshifted character of a key, NO_CHAR where nothing prints
    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] c;
        c = NO_CHAR;
        case (key)
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd57: c = 7'h20;
            default: c = NO_CHAR;
        endcase
        return c;
    endfunction

    // shifted character of a key, NO_CHAR where nothing prints
    function automatic logic [6:0] shifted_char(input logic [6:0] key);
        logic [6:0] c;
        c = NO_CHAR;
        case (key)
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h5E;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd16: c = 7'h51;
            7'd17: c = 7'h57;
            7'd18: c = 7'h45;
            7'd19: c = 7'h52;
            7'd20: c = 7'h54;
            7'd21: c = 7'h59;
            7'd22: c = 7'h55;
            7'd23: c = 7'h49;
            7'd24: c = 7'h4F;
            7'd25: c = 7'h50;
            7'd26: c = 7'h7B;
            7'd27: c = 7'h7D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h41;
            7'd31: c = 7'h53;
            7'd32: c = 7'h44;
            7'd33: c = 7'h46;
            7'd34: c = 7'h47;
            7'd35: c = 7'h48;
            7'd36: c = 7'h4A;
            7'd37: c = 7'h4B;
            7'd38: c = 7'h4C;
            7'd39: c = 7'h3A;
            7'd40: c = 7'h22;
            7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;
            7'd44: c = 7'h5A;
            7'd45: c = 7'h58;
            7'd46: c = 7'h43;
            7'd47: c = 7'h56;
            7'd48: c = 7'h42;
            7'd49: c = 7'h4E;
            7'd50: c = 7'h4D;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd57: c = 7'h20;
            default: c = NO_CHAR;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/keyboard_scancode_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder
// set-1 scancode decoder with key map, shift tracking and event ring
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | content
//  --------+------------------------------+-----------+-------------------------
//  req     | req_valid, req_ready, req    | in        | request type, code byte
//  rsp     | rsp_valid, rsp_ready, rsp    | out       | one result per request
//
//  one request transfer per cycle sustained while rsp is ready; a result
//  goes through the request stage, then the result register, and can
//  transfer from the result register
//  the extra stage comes from the registered read port of the event ring
//  reset clears key map, shift, ring pointers and both stage valids; the
//  ring storage itself is not cleared, only written entries are ever popped
//  a stalled rsp holds the result register, then the request stage, then req
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder
    import ksd_pkg::*;
#(
    parameter int EVENT_DEPTH = 64
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire ksd_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output ksd_rsp_t      rsp
);

    localparam int PTR_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(EVENT_DEPTH - 1);

    // per-key down flags, cleared at reset
    logic [KEY_COUNT-1:0] key_map_reg;
    logic [KEY_COUNT-1:0] key_map_next;
    logic                 shift_reg;
    logic                 shift_next;
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;

    // event ring storage: bit 7 pressed flag, bits 6..0 key code
    logic [7:0] ev_mem [EVENT_DEPTH];
    logic [7:0] ev_rdata_reg;

    // request stage
    logic     s1_valid_reg;
    ksd_rsp_t s1_res_reg;
    logic     s1_pop_reg;
    ksd_rsp_t s1_res_next;
    logic     s1_pop_next;

    // result register
    logic     rsp_valid_reg;
    ksd_rsp_t rsp_reg;
    ksd_rsp_t rsp_next;

    logic       req_xfer;
    logic       s1_advance;
    logic [6:0] key;
    logic       pressed;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic       ring_full;
    logic       ring_empty;
    logic       shift_eff;
    logic [6:0] char_sel;
    logic       ev_write;
    logic       ev_read;

    // handshake: each stage moves when the one after it has room
    assign s1_advance = !rsp_valid_reg || rsp_ready;
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign req_xfer   = req_valid && req_ready;

    assign key     = req.code_byte[6:0];
    assign pressed = !req.code_byte[7];

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    // ring keeps one slot free so full and empty differ
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);

    // shift state of this scancode counts for its own lookup
    assign shift_eff = (key == SHIFT_LEFT_CODE || key == SHIFT_RIGHT_CODE)
                       ? pressed : shift_reg;
    assign char_sel  = shift_eff ? shifted_char(key) : plain_char(key);

    always_comb
    begin
        key_map_next = key_map_reg;
        shift_next   = shift_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        s1_res_next  = '0;
        s1_pop_next  = 1'b0;
        ev_write     = 1'b0;
        ev_read      = 1'b0;
        if (req_xfer)
        begin
            unique case (req.req_type)
                REQ_SCAN:
                begin
                    key_map_next[key] = pressed;
                    shift_next        = shift_eff;
                    if (ring_full)
                    begin
                        s1_res_next.event_dropped = 1'b1;
                    end
                    else
                    begin
                        ev_write    = 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                    end
                    // '?' entries and keys past the table give no character
                    if (pressed && char_sel != NO_CHAR)
                    begin
                        s1_res_next.char_valid = 1'b1;
                        s1_res_next.char_code  = char_sel;
                    end
                end
                REQ_POP:
                begin
                    if (ring_empty)
                    begin
                        s1_res_next.event_empty = 1'b1;
                    end
                    else
                    begin
                        ev_read     = 1'b1;
                        s1_pop_next = 1'b1;
                        rd_ptr_next = rd_ptr_inc;
                    end
                end
                REQ_QUERY:
                begin
                    if (!req.code_byte[7])
                    begin
                        s1_res_next.key_down = key_map_reg[key];
                    end
                end
                default:
                begin
                    // reserved type: all-zero result, no state change
                end
            endcase
        end
    end

    // merge popped event data into the result
    always_comb
    begin
        rsp_next = s1_res_reg;
        if (s1_pop_reg)
        begin
            rsp_next.event_scancode = ev_rdata_reg[6:0];
            rsp_next.event_pressed  = ev_rdata_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_write)
        begin
            ev_mem[wr_ptr_reg] <= {pressed, key};
        end
        if (ev_read)
        begin
            ev_rdata_reg <= ev_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg   <= '0;
            shift_reg     <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            key_map_reg <= key_map_next;
            shift_reg   <= shift_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage payloads, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_res_reg <= s1_res_next;
            s1_pop_reg <= s1_pop_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// self-checking test of the set-1 scancode decoder
// ----------------------------------------------------------------------------
// requests go in through a valid/ready sender that can pause at random. A
// monitor predicts one response per accepted request transfer from its own
// copy of the key map, the shift state and the event ring. It then compares
// each response transfer, field by field, with the oldest prediction. The
// response side stalls in random bursts. The last phase runs with no pauses.
// ----------------------------------------------------------------------------
module testbench;
    import ksd_pkg::*;

    localparam int         RING_DEPTH  = 64;     // matches the dut default
    localparam int         TABLE_SIZE  = 58;     // keys with a character entry
    localparam logic [1:0] REQ_NONE    = 2'd3;   // unused request type
    localparam int         PRINT_LIMIT = 10;

    // character tables indexed by key code, '?' means nothing prints
    string plain_keys   = "??1234567890-=??qwertyuiop[]\n?asdfghjkl;'`?\\zxcvbnm,./??? ";
    string shifted_keys = "??!@#$%^&*()_+??QWERTYUIOP{}\n?ASDFGHJKL:\"~?|ZXCVBNM<>???? ";

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    ksd_req_t req       = '0;
    logic     rsp_ready = 1'b0;
    logic     req_ready;
    logic     rsp_valid;
    ksd_rsp_t rsp;

    // predicted decoder state
    bit         key_held [KEY_COUNT];
    bit         shift_on;
    logic [7:0] event_ring [$];         // pressed flag in bit 7, key in 6..0

    ksd_rsp_t   pending_rsp [$];        // predicted responses, oldest first
    ksd_rsp_t   expected_rsp;
    bit         idling_on = 1'b1;
    int         error_count = 0;
    logic [6:0] last_key = '0;

    keyboard_scancode_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // hard stop in case a response never shows up
    initial
    begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor: applies one request to the modeled state, returns the response
    // ------------------------------------------------------------------------
    function automatic ksd_rsp_t decode_request(input ksd_req_t r);
        ksd_rsp_t   o;
        logic [6:0] key;
        logic       pressed;
        logic [7:0] c;
        logic [7:0] ev;
        o       = '0;
        key     = r.code_byte[6:0];
        pressed = ~r.code_byte[7];
        case (r.req_type)
            REQ_SCAN:
            begin
                // map and shift follow every scancode, even a dropped one
                key_held[key] = pressed;
                if (event_ring.size() < RING_DEPTH - 1)
                    event_ring.push_back({pressed, key});
                else
                    o.event_dropped = 1'b1;
                if (key == SHIFT_LEFT_CODE || key == SHIFT_RIGHT_CODE)
                    shift_on = pressed;
                // only a press of a key inside the table can print
                if (pressed && key < TABLE_SIZE)
                begin
                    c = shift_on ? shifted_keys[key] : plain_keys[key];
                    if (c[6:0] != NO_CHAR)
                    begin
                        o.char_valid = 1'b1;
                        o.char_code  = c[6:0];
                    end
                end
            end
            REQ_POP:
            begin
                if (event_ring.size() == 0)
                    o.event_empty = 1'b1;
                else
                begin
                    ev               = event_ring.pop_front();
                    o.event_scancode = ev[6:0];
                    o.event_pressed  = ev[7];
                end
            end
            REQ_QUERY:
            begin
                // codes 128 and up are never held
                if (!r.code_byte[7])
                    o.key_down = key_held[r.code_byte[6:0]];
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("error at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // monitor: predict on each request transfer, check each response transfer
    // samples right after the edge, so both see pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                pending_rsp.push_back(decode_request(req));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                    log_error("response transfer with no request outstanding");
                else
                begin
                    expected_rsp = pending_rsp.pop_front();
                    if (rsp.char_valid !== expected_rsp.char_valid
                        || rsp.char_code !== expected_rsp.char_code
                        || rsp.event_scancode !== expected_rsp.event_scancode
                        || rsp.event_pressed !== expected_rsp.event_pressed
                        || rsp.event_empty !== expected_rsp.event_empty
                        || rsp.key_down !== expected_rsp.key_down
                        || rsp.event_dropped !== expected_rsp.event_dropped)
                        log_error($sformatf({"chr %b/%h ev %h/%b empty %b key %b drop %b,",
                            " expected chr %b/%h ev %h/%b empty %b key %b drop %b"},
                            rsp.char_valid, rsp.char_code, rsp.event_scancode,
                            rsp.event_pressed, rsp.event_empty, rsp.key_down,
                            rsp.event_dropped, expected_rsp.char_valid,
                            expected_rsp.char_code, expected_rsp.event_scancode,
                            expected_rsp.event_pressed, expected_rsp.event_empty,
                            expected_rsp.key_down, expected_rsp.event_dropped));
                end
            end
        end
    end

    // response side: ready runs of random length broken by short stalls
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(10, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            if (idling_on)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one request transfer, with an occasional pause before it
    // valid stays high between back-to-back requests
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] kind, input logic [7:0] code);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{req_type: kind, code_byte: code};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // mostly keys with a character, some from the whole code range
    function automatic logic [6:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return 7'($urandom_range(0, KEY_COUNT - 1));
        return 7'($urandom_range(0, TABLE_SIZE - 1));
    endfunction

    // mixed traffic: scancodes, pops, queries and the odd unused type
    task automatic send_random_mix(input int count, input int pop_pct);
        int         roll;
        logic [6:0] key;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            key  = pick_key();
            if (roll < pop_pct)
                send_request(REQ_POP, 8'($urandom));
            else if (roll < pop_pct + 12)
                send_request(REQ_QUERY,
                    $urandom_range(0, 1) ? {1'b0, last_key} : 8'($urandom));
            else if (roll < pop_pct + 15)
                send_request(REQ_NONE, 8'($urandom));
            else if ($urandom_range(0, 2) == 0)
                // release, often of the key pressed last
                send_request(REQ_SCAN, {1'b1, $urandom_range(0, 1) ? last_key : key});
            else
            begin
                send_request(REQ_SCAN, {1'b0, key});
                last_key = key;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, every request type and the named corner cases
    task automatic test_directed();
        send_request(REQ_POP,   8'h00);                     // pop of an empty ring
        send_request(REQ_NONE,  8'hFF);                     // unused type, all zeros
        send_request(REQ_SCAN,  8'h00);                     // key 0 prints nothing
        send_request(REQ_SCAN,  8'h1E);                     // 'a'
        send_request(REQ_SCAN,  8'h1C);                     // newline
        send_request(REQ_SCAN,  {1'b0, SHIFT_LEFT_CODE});   // shift itself is silent
        send_request(REQ_SCAN,  8'h10);                     // 'Q'
        send_request(REQ_SCAN,  8'h35);                     // shifted slash is silent
        send_request(REQ_SCAN,  8'h02);                     // '!'
        send_request(REQ_QUERY, {1'b0, SHIFT_LEFT_CODE});
        send_request(REQ_SCAN,  {1'b1, SHIFT_LEFT_CODE});
        send_request(REQ_SCAN,  {1'b0, SHIFT_RIGHT_CODE});
        send_request(REQ_SCAN,  8'h29);                     // '~'
        send_request(REQ_SCAN,  {1'b1, SHIFT_RIGHT_CODE});
        send_request(REQ_SCAN,  8'h39);                     // space, last table entry
        send_request(REQ_SCAN,  8'h3A);                     // first key past the table
        send_request(REQ_SCAN,  8'h7F);                     // highest key pressed
        send_request(REQ_QUERY, 8'h7F);
        send_request(REQ_QUERY, 8'hFF);                     // query above the map
        send_request(REQ_QUERY, 8'h80);
        send_request(REQ_SCAN,  8'hFF);                     // release of key 127
        send_request(REQ_QUERY, 8'h7F);
        repeat (3)
            send_request(REQ_POP, 8'hFF);
        send_request(REQ_NONE,  8'h00);
    endtask

    task automatic test_typing();
        send_random_mix(450, 25);
    endtask

    // shift held across short words, released by either shift key
    task automatic test_shifted_typing();
        logic [6:0] shift_key;
        logic [6:0] key;
        repeat (25)
        begin
            shift_key = $urandom_range(0, 1) ? SHIFT_LEFT_CODE : SHIFT_RIGHT_CODE;
            send_request(REQ_SCAN, {1'b0, shift_key});
            repeat ($urandom_range(1, 8))
            begin
                key = pick_key();
                send_request(REQ_SCAN, {1'b0, key});
                if ($urandom_range(0, 3) == 0)
                    send_request(REQ_QUERY, {1'b0, key});
                send_request(REQ_SCAN, {1'b1, key});
            end
            // a release of the other shift key also ends shift
            if ($urandom_range(0, 4) == 0)
                shift_key = (shift_key == SHIFT_LEFT_CODE) ? SHIFT_RIGHT_CODE
                                                           : SHIFT_LEFT_CODE;
            send_request(REQ_SCAN, {1'b1, shift_key});
            repeat ($urandom_range(2, 6))
                send_request(REQ_POP, 8'($urandom));
        end
    endtask

    // overfill the ring so events drop, then drain it past empty
    task automatic test_ring_full();
        repeat (2)
        begin
            repeat (RING_DEPTH + 6)
                send_request(REQ_SCAN, 8'($urandom));
            repeat (RING_DEPTH + 4)
                send_request(REQ_POP, 8'($urandom));
        end
    endtask

    // back-to-back transfers with no pauses on either side
    task automatic test_steady_stream();
        send_random_mix(400, 45);
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_typing();
        test_shifted_typing();
        test_ring_full();
        idling_on = 1'b0;
        test_steady_stream();
        req_valid <= 1'b0;

        // drain, then keep waiting to catch stray responses
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hdl/ksd_pkg.sv
hdl/keyboard_scancode_decoder.sv
test/testbench.sv
